>>> rtl/tdf_pkg.sv
package tdf_pkg;

    // width of the value being factored and of every factor
    localparam int VALUE_WIDTH = 31;

    // bit counter for one serial divide
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    // first trial divisor
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE,
        ST_EMIT
    } tdf_state_t;

endpackage

>>> rtl/trial_division_factorizer_core.sv
// trial division prime factorizer
//
// input channel: item_valid / item_stall with the value word; one word is taken
// when item_valid is high and item_stall is low. item_stall stays high from the
// cycle after a word is taken until its last factor is in the output register
// output channel: result_valid / result_stall with factor, no_factor and last;
// one word per prime factor in ascending order with repeats, last marks the
// final one. a value of 0 or 1 gives a single word with no_factor and last set
// and a zero factor
// one restoring divider, one quotient bit per cycle, is shared by every trial:
// a trial is VALUE_WIDTH divide steps and a decide state, each factor found costs
// one more trial and a pass through the emit state; a prime v is the worst case:
// trials run from 2 to floor(sqrt(v)) + 1
// the factor word sits in an output register, so a stalled receiver only holds
// the sequencer in its emit state; nothing is dropped or repeated
// reset (rst_n low, asynchronous) returns the sequencer to idle and empties
// the output register
module trial_division_factorizer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [tdf_pkg::VALUE_WIDTH-1:0] value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tdf_pkg::VALUE_WIDTH-1:0] factor,
    output logic                          no_factor,
    output logic                          last
);
    import tdf_pkg::*;

    tdf_state_t state_reg, state_next;

    // working remainder and current trial divisor
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] div_reg;

    // serial divider: quotient shifts in while dividend bits shift out
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [VALUE_WIDTH-1:0] part_reg;
    logic [CNT_WIDTH-1:0]   count_reg;

    // factor waiting for the output register
    logic [VALUE_WIDTH-1:0] pend_factor_reg;
    logic                   pend_nf_reg;
    logic                   pend_last_reg;

    // output register
    logic                   result_valid_reg;
    logic [VALUE_WIDTH-1:0] factor_reg;
    logic                   no_factor_reg;
    logic                   last_reg;

    logic                   accept;
    logic                   small_value;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic                   div_done;
    logic                   stop;
    logic                   even;
    logic                   slot_free;
    logic                   load_div;
    logic                   step_div;
    logic                   load_out;
    logic                   busy;

    // datapath terms
    assign accept      = item_valid && !item_stall;
    assign small_value = (value[VALUE_WIDTH-1:1] == '0);
    assign trial       = {part_reg, quot_reg[VALUE_WIDTH-1]};
    assign diff        = trial - {1'b0, div_reg};
    assign fits        = (trial >= {1'b0, div_reg});
    assign div_done    = (count_reg == '0);
    // divisor above quotient: divisor squared exceeds the remainder
    assign stop        = (div_reg > quot_reg);
    assign even        = (part_reg == '0);
    assign slot_free   = !result_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = small_value ? ST_EMIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (stop || even) ? ST_EMIT : ST_DIVIDE;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = pend_last_reg ? ST_IDLE : ST_DIVIDE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy     = 1'b1;
        step_div = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:   busy = 1'b0;
            ST_DIVIDE: step_div = 1'b1;
            ST_DECIDE: busy = 1'b1;
            ST_EMIT:   load_out = slot_free;
            default:   busy = 1'b1;
        endcase
        load_div = (state_next == ST_DIVIDE) && (state_reg != ST_DIVIDE);
    end

    assign item_stall = busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // remainder, divisor and pending factor
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_reg         <= value;
            div_reg         <= FIRST_DIVISOR;
            pend_factor_reg <= '0;
            pend_nf_reg     <= 1'b1;
            pend_last_reg   <= 1'b1;
        end
        else if (state_reg == ST_DECIDE)
        begin
            if (stop)
            begin
                pend_factor_reg <= rem_reg;
                pend_nf_reg     <= 1'b0;
                pend_last_reg   <= 1'b1;
            end
            else if (even)
            begin
                pend_factor_reg <= div_reg;
                pend_nf_reg     <= 1'b0;
                pend_last_reg   <= 1'b0;
                rem_reg         <= quot_reg;
            end
            else
            begin
                div_reg <= div_reg + VALUE_WIDTH'(1);
            end
        end
    end

    // shared restoring divider
    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            quot_reg  <= (state_reg == ST_IDLE) ? value : rem_reg;
            part_reg  <= '0;
            count_reg <= CNT_WIDTH'(VALUE_WIDTH - 1);
        end
        else if (step_div)
        begin
            quot_reg  <= {quot_reg[VALUE_WIDTH-2:0], fits};
            part_reg  <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            count_reg <= count_reg - CNT_WIDTH'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            factor_reg    <= pend_factor_reg;
            no_factor_reg <= pend_nf_reg;
            last_reg      <= pend_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign factor       = factor_reg;
    assign no_factor    = no_factor_reg;
    assign last         = last_reg;

    // checks
    a_no_factor_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_factor |-> last && (factor == '0))
        else $error("no-factor word must be final and carry zero");

    a_real_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !no_factor |-> (factor >= VALUE_WIDTH'(2)))
        else $error("real factor below two");

    a_divide_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && !div_done |=> (state_reg == ST_DIVIDE))
        else $error("divide left before all quotient bits");

    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (div_reg >= FIRST_DIVISOR))
        else $error("trial divisor below two");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after taking a word");

endmodule
